// ===== design/huffman_code_builder_unit_macros.svh =====
// Assertion macros shared by the huffman code builder RTL.
`ifndef HUFFMAN_CODE_BUILDER_UNIT_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define HCB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("hcb assertion failed");
`define HCB_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("hcb forbidden condition seen");
`else
`define HCB_ASSERT(lbl, clk, rst, prop)
`define HCB_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== design/hcb_pkg.sv =====
`default_nettype none
package hcb_pkg;
   localparam int DEF_MAX_SYMBOLS = 64;
   localparam int DEF_FREQ_BITS   = 16;
   localparam int SYM_W           = 8;
   localparam int IN_FREQ_W       = 16;
   localparam int LEN_W           = 6;
   localparam int CODE_W          = 63;
   localparam int WSUM_W          = 28;
   localparam int REQ_DATA_W      = 24;
   localparam int RSP_DATA_W      = 112;
   localparam logic [WSUM_W-1:0] WSUM_MAX = {WSUM_W{1'b1}};

   typedef struct packed {
      logic push;
      logic pop;
   } stk_ctl_type;

   typedef struct packed {
      logic clear;
      logic add;
   } acc_ctl_type;
endpackage
`default_nettype wire

// ===== design/hcb_walk_stack.sv =====
`default_nettype none
`include "huffman_code_builder_unit_macros.svh"
module hcb_walk_stack
   import hcb_pkg::*;
#(
   parameter int DEPTH   = DEF_MAX_SYMBOLS,
   parameter int ENTRY_W = 7 + LEN_W + CODE_W
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire stk_ctl_type        ctl,
   input  wire logic [ENTRY_W-1:0] push_data,
   output logic      [ENTRY_W-1:0] pop_data,
   output logic                    empty
);
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SP_W = $clog2(DEPTH + 1);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [SP_W-1:0]    sp_ff;
   logic [SP_W-1:0]    sp_dec;
   logic               full;

   assign sp_dec = sp_ff - SP_W'(1);
   assign empty  = (sp_ff == '0);
   assign full   = (sp_ff == SP_W'(DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else if (ctl.push) begin
         sp_ff <= sp_ff + SP_W'(1);
      end else if (ctl.pop) begin
         sp_ff <= sp_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[sp_ff[AW-1:0]] <= push_data;
      end
      if (ctl.pop) begin
         pop_data <= mem[sp_dec[AW-1:0]];
      end
   end

   `HCB_NEVER(a_push_full, clock, reset, ctl.push && full)
   `HCB_NEVER(a_pop_empty, clock, reset, ctl.pop && empty)
   `HCB_NEVER(a_push_pop, clock, reset, ctl.push && ctl.pop)
   `HCB_ASSERT(a_push_grow, clock, reset, ctl.push |=> (sp_ff == $past(sp_ff) + SP_W'(1)))
endmodule
`default_nettype wire

// ===== design/hcb_wsum_acc.sv =====
`default_nettype none
`include "huffman_code_builder_unit_macros.svh"
module hcb_wsum_acc
   import hcb_pkg::*;
#(
   parameter int WT_W = DEF_FREQ_BITS + 7
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire acc_ctl_type       ctl,
   input  wire logic [WT_W-1:0]   weight,
   input  wire logic [LEN_W-1:0]  depth,
   output logic      [WSUM_W-1:0] wsum
);
   localparam int SUM_W = ((WT_W + LEN_W) > WSUM_W ? (WT_W + LEN_W) : WSUM_W) + 1;

   logic [WSUM_W-1:0]     wsum_ff;
   logic [WT_W+LEN_W-1:0] prod;
   logic [SUM_W-1:0]      sum;

   assign prod = (WT_W + LEN_W)'(weight) * (WT_W + LEN_W)'(depth);
   assign sum  = SUM_W'(wsum_ff) + SUM_W'(prod);
   assign wsum = wsum_ff;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         wsum_ff <= '0;
      end else if (ctl.add) begin
         // saturate at the field maximum
         wsum_ff <= (sum > SUM_W'(WSUM_MAX)) ? WSUM_MAX : sum[WSUM_W-1:0];
      end
   end

   `HCB_NEVER(a_clear_add, clock, reset, ctl.clear && ctl.add)
   `HCB_ASSERT(a_monotone, clock, reset, ctl.add |=> (wsum_ff >= $past(wsum_ff)))
   `HCB_ASSERT(a_cleared, clock, reset, ctl.clear |=> (wsum_ff == '0))
endmodule
`default_nettype wire

// ===== design/huffman_code_builder_unit.sv =====
// Huffman code builder.
// Input stream req_*: one (symbol, frequency) transaction per cycle while
// req_tready is high; req_tlast marks the final pair of a batch and starts
// the build. Pairs beyond MAX_SYMBOLS are dropped, but their tlast still
// starts the build. req_tready then stays low until the batch is done.
// Output stream rsp_*: one transaction per leaf in depth-first order, left
// first; rsp_tlast marks the final leaf. A single symbol gives length 0.
// The build runs under one sequencer; heap and node-weight memories each
// have one read port and one write port. Sift-down steps first heapify the
// batch; each merge then pops two nodes, re-sifting after each pop, and
// pushes a node of their summed weight by sift-up, before the walk starts.
// A stalled receiver holds rsp_tdata and rsp_tlast; the walk waits.
// Reset (synchronous) empties the batch and the walk stack; no memory
// clearing pass is needed, so req_tready rises in the cycle after reset.
`default_nettype none
`include "huffman_code_builder_unit_macros.svh"
module huffman_code_builder_unit
   import hcb_pkg::*;
#(
   parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
   parameter int FREQ_BITS   = DEF_FREQ_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [7:0] symbol, [23:8] frequency
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // last_symbol
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [7:0] leaf_symbol, [13:8] code_length, [76:14] code_bits,
   // [104:77] weighted_bits, [111:105] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // last_code
   output logic                       rsp_tlast
);
   localparam int NODE_CAP = 2 * MAX_SYMBOLS - 1;
   localparam int NIDX_W   = (NODE_CAP > 1) ? $clog2(NODE_CAP) : 1;
   localparam int HA_W     = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int CNT_W    = $clog2(MAX_SYMBOLS + 1);
   localparam int HX_W     = CNT_W + 1;
   localparam int W_W      = FREQ_BITS + CNT_W;
   localparam int CMP_W    = NIDX_W + CNT_W;
   localparam int ENTRY_W  = NIDX_W + LEN_W + CODE_W;
   localparam int PAD_W    = RSP_DATA_W - SYM_W - LEN_W - CODE_W - WSUM_W;

   typedef enum logic [4:0] {
      S_LOAD, S_HFY, S_HFY_X, S_HFY_W, S_SD, S_SD_L, S_SD_LW, S_SD_RW, S_SD_DEC,
      S_MRG, S_POP0, S_POP1, S_POP2, S_POP3, S_SUMA, S_SUMB, S_SUMC,
      S_PU, S_PU_H, S_PU_W, S_WROOT, S_WROOT2, S_WK, S_WK_RD, S_OUT, S_SPOP
   } state_type;

   state_type state_ff;

   logic [SYM_W-1:0]  sym_mem   [MAX_SYMBOLS];
   logic [W_W-1:0]    wgt_mem   [NODE_CAP];
   logic [NIDX_W-1:0] left_mem  [NODE_CAP];
   logic [NIDX_W-1:0] right_mem [NODE_CAP];
   logic [NIDX_W-1:0] heap_mem  [MAX_SYMBOLS];

   logic [SYM_W-1:0]  sym_rd_ff;
   logic [W_W-1:0]    wgt_rd_ff;
   logic [NIDX_W-1:0] left_rd_ff, right_rd_ff, heap_rd_ff;

   logic [CNT_W-1:0]  loaded_ff, cnt_ff, n_ff;
   logic [HA_W-1:0]   s_ff, p_ff, i_ff;
   logic [NIDX_W-1:0] x_ff, cl_ff, cr_ff, top_ff, a_ff, b_ff, pn_ff, next_ff;
   logic [W_W-1:0]    wx_ff, wl_ff, wr_ff, wa_ff;
   logic              popn_ff, from_pop_ff;
   logic [NIDX_W-1:0] cur_ff;
   logic [LEN_W-1:0]  dep_ff;
   logic [CODE_W-1:0] code_ff;

   logic              rsp_valid_ff, out_last_ff;
   logic [SYM_W-1:0]  out_sym_ff;
   logic [LEN_W-1:0]  out_len_ff;
   logic [CODE_W-1:0] out_code_ff;

   logic              heap_we, wgt_we, lr_we, sym_we;
   logic [HA_W-1:0]   heap_ra, heap_wa;
   logic [NIDX_W-1:0] heap_wd, wgt_ra, wgt_wa;
   logic [W_W-1:0]    wgt_wd;

   logic              req_acc, rsp_acc, room;
   logic [CNT_W-1:0]  ln_new;
   logic [HA_W-1:0]   hs_start;
   logic [HX_W-1:0]   l_idx, r_idx;
   logic              l_ok, r_ok, take_l, take_r, move, sd_done, is_leaf;
   logic [W_W-1:0]    bw, sum_w;
   logic [NIDX_W-1:0] bn;
   logic [HA_W-1:0]   parent;
   logic [IN_FREQ_W+FREQ_BITS-1:0] freq_ext;

   stk_ctl_type       stk_ctl;
   acc_ctl_type       acc_ctl;
   logic [ENTRY_W-1:0] stk_push, stk_pop;
   logic              stk_empty;
   logic [WSUM_W-1:0] wsum;

   assign req_tready = (state_ff == S_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_acc    = rsp_valid_ff && rsp_tready;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, wsum, out_code_ff, out_len_ff, out_sym_ff};

   assign room     = (loaded_ff < CNT_W'(MAX_SYMBOLS));
   assign ln_new   = loaded_ff + CNT_W'(room);
   assign hs_start = (ln_new >= CNT_W'(2)) && (CNT_W > 1)
                     ? HA_W'((ln_new - CNT_W'(2)) >> 1) : '0;
   assign freq_ext = {{FREQ_BITS{1'b0}}, req_tdata[SYM_W +: IN_FREQ_W]};

   assign l_idx   = HX_W'({p_ff, 1'b0}) + HX_W'(1);
   assign r_idx   = l_idx + HX_W'(1);
   assign l_ok    = l_idx < HX_W'(cnt_ff);
   assign r_ok    = r_idx < HX_W'(cnt_ff);
   assign take_l  = wl_ff < wx_ff;
   assign bw      = take_l ? wl_ff : wx_ff;
   assign take_r  = r_ok && (wr_ff < bw);
   assign move    = take_l || take_r;
   assign bn      = take_r ? cr_ff : cl_ff;
   assign sd_done = ((state_ff == S_SD) && !l_ok) || ((state_ff == S_SD_DEC) && !move);
   assign parent  = (i_ff - HA_W'(1)) >> 1;
   assign sum_w   = wa_ff + wgt_rd_ff;
   assign is_leaf = CMP_W'(cur_ff) < CMP_W'(n_ff);
   assign stk_push = {right_rd_ff, dep_ff + LEN_W'(1), code_ff[CODE_W-2:0], 1'b1};

   always_comb begin
      heap_we = 1'b0;
      heap_ra = '0;
      heap_wa = p_ff;
      heap_wd = x_ff;
      wgt_ra  = cur_ff;
      wgt_we  = 1'b0;
      wgt_wa  = next_ff;
      wgt_wd  = sum_w;
      lr_we   = 1'b0;
      sym_we  = 1'b0;
      stk_ctl = '0;
      acc_ctl = '0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_acc && room) begin
               sym_we  = 1'b1;
               wgt_we  = 1'b1;
               wgt_wa  = NIDX_W'(loaded_ff);
               wgt_wd  = W_W'(freq_ext[FREQ_BITS-1:0]);
               heap_we = 1'b1;
               heap_wa = loaded_ff[HA_W-1:0];
               heap_wd = NIDX_W'(loaded_ff);
            end
         end
         S_HFY:   heap_ra = s_ff;
         S_HFY_X: wgt_ra  = heap_rd_ff;
         S_SD: begin
            heap_ra = l_idx[HA_W-1:0];
            heap_we = !l_ok;
         end
         S_SD_L: begin
            wgt_ra  = heap_rd_ff;
            heap_ra = r_idx[HA_W-1:0];
         end
         S_SD_LW: wgt_ra = heap_rd_ff;
         S_SD_DEC: begin
            heap_we = 1'b1;
            heap_wd = move ? bn : x_ff;
         end
         S_POP1: heap_ra = HA_W'(cnt_ff - CNT_W'(1));
         S_POP2: wgt_ra  = heap_rd_ff;
         S_SUMA: wgt_ra  = a_ff;
         S_SUMB: wgt_ra  = b_ff;
         S_SUMC: begin
            wgt_we = 1'b1;
            lr_we  = 1'b1;
         end
         S_PU: begin
            heap_ra = parent;
            if (i_ff == '0) begin
               heap_we = 1'b1;
               heap_wa = i_ff;
               heap_wd = next_ff;
            end
         end
         S_PU_H: wgt_ra = heap_rd_ff;
         S_PU_W: begin
            heap_we = 1'b1;
            heap_wa = i_ff;
            heap_wd = (wgt_rd_ff > wx_ff) ? pn_ff : next_ff;
         end
         S_WROOT: acc_ctl.clear = 1'b1;
         S_WK_RD: begin
            acc_ctl.add  = is_leaf;
            stk_ctl.push = !is_leaf;
         end
         S_OUT: stk_ctl.pop = rsp_acc && !out_last_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (sym_we) begin
         sym_mem[loaded_ff[HA_W-1:0]] <= req_tdata[SYM_W-1:0];
      end
      if (wgt_we) begin
         wgt_mem[wgt_wa] <= wgt_wd;
      end
      if (lr_we) begin
         left_mem[next_ff]  <= a_ff;
         right_mem[next_ff] <= b_ff;
      end
      if (heap_we) begin
         heap_mem[heap_wa] <= heap_wd;
      end
      heap_rd_ff  <= heap_mem[heap_ra];
      wgt_rd_ff   <= wgt_mem[wgt_ra];
      left_rd_ff  <= left_mem[cur_ff];
      right_rd_ff <= right_mem[cur_ff];
      sym_rd_ff   <= sym_mem[cur_ff[HA_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         loaded_ff    <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_LOAD: begin
               if (req_acc) begin
                  loaded_ff <= ln_new;
                  if (req_tlast) begin
                     n_ff     <= ln_new;
                     cnt_ff   <= ln_new;
                     next_ff  <= NIDX_W'(ln_new);
                     s_ff     <= hs_start;
                     state_ff <= S_HFY;
                  end
               end
            end
            S_HFY:   state_ff <= S_HFY_X;
            S_HFY_X: begin
               x_ff     <= heap_rd_ff;
               state_ff <= S_HFY_W;
            end
            S_HFY_W: begin
               wx_ff       <= wgt_rd_ff;
               p_ff        <= s_ff;
               from_pop_ff <= 1'b0;
               state_ff    <= S_SD;
            end
            S_SD: begin
               if (l_ok) begin
                  state_ff <= S_SD_L;
               end
            end
            S_SD_L: begin
               cl_ff    <= heap_rd_ff;
               state_ff <= S_SD_LW;
            end
            S_SD_LW: begin
               wl_ff    <= wgt_rd_ff;
               cr_ff    <= heap_rd_ff;
               state_ff <= r_ok ? S_SD_RW : S_SD_DEC;
            end
            S_SD_RW: begin
               wr_ff    <= wgt_rd_ff;
               state_ff <= S_SD_DEC;
            end
            S_SD_DEC: begin
               if (move) begin
                  p_ff     <= take_r ? r_idx[HA_W-1:0] : l_idx[HA_W-1:0];
                  state_ff <= S_SD;
               end
            end
            S_MRG: begin
               popn_ff  <= 1'b0;
               state_ff <= (cnt_ff > CNT_W'(1)) ? S_POP0 : S_WROOT;
            end
            S_POP0: state_ff <= S_POP1;
            S_POP1: begin
               top_ff   <= heap_rd_ff;
               state_ff <= S_POP2;
            end
            S_POP2: begin
               x_ff     <= heap_rd_ff;
               cnt_ff   <= cnt_ff - CNT_W'(1);
               state_ff <= S_POP3;
            end
            S_POP3: begin
               wx_ff       <= wgt_rd_ff;
               p_ff        <= '0;
               from_pop_ff <= 1'b1;
               state_ff    <= S_SD;
            end
            S_SUMA: state_ff <= S_SUMB;
            S_SUMB: begin
               wa_ff    <= wgt_rd_ff;
               state_ff <= S_SUMC;
            end
            S_SUMC: begin
               wx_ff    <= sum_w;
               i_ff     <= cnt_ff[HA_W-1:0];
               cnt_ff   <= cnt_ff + CNT_W'(1);
               state_ff <= S_PU;
            end
            S_PU: begin
               if (i_ff == '0) begin
                  next_ff  <= next_ff + NIDX_W'(1);
                  state_ff <= S_MRG;
               end else begin
                  state_ff <= S_PU_H;
               end
            end
            S_PU_H: begin
               pn_ff    <= heap_rd_ff;
               state_ff <= S_PU_W;
            end
            S_PU_W: begin
               if (wgt_rd_ff > wx_ff) begin
                  i_ff     <= parent;
                  state_ff <= S_PU;
               end else begin
                  next_ff  <= next_ff + NIDX_W'(1);
                  state_ff <= S_MRG;
               end
            end
            S_WROOT: state_ff <= S_WROOT2;
            S_WROOT2: begin
               cur_ff   <= heap_rd_ff;
               dep_ff   <= '0;
               code_ff  <= '0;
               state_ff <= S_WK;
            end
            S_WK: state_ff <= S_WK_RD;
            S_WK_RD: begin
               if (is_leaf) begin
                  out_sym_ff   <= sym_rd_ff;
                  out_len_ff   <= dep_ff;
                  out_code_ff  <= code_ff;
                  out_last_ff  <= stk_empty;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_OUT;
               end else begin
                  // descend left; the right child waits on the stack
                  cur_ff   <= left_rd_ff;
                  dep_ff   <= dep_ff + LEN_W'(1);
                  code_ff  <= {code_ff[CODE_W-2:0], 1'b0};
                  state_ff <= S_WK;
               end
            end
            S_OUT: begin
               if (rsp_acc) begin
                  rsp_valid_ff <= 1'b0;
                  if (out_last_ff) begin
                     loaded_ff <= '0;
                     cnt_ff    <= '0;
                     state_ff  <= S_LOAD;
                  end else begin
                     state_ff <= S_SPOP;
                  end
               end
            end
            S_SPOP: begin
               {cur_ff, dep_ff, code_ff} <= stk_pop;
               state_ff <= S_WK;
            end
            default: state_ff <= S_LOAD;
         endcase

         // hand a finished sift back to whoever started it
         if (sd_done) begin
            if (!from_pop_ff) begin
               if (s_ff == '0) begin
                  state_ff <= S_MRG;
               end else begin
                  s_ff     <= s_ff - HA_W'(1);
                  state_ff <= S_HFY;
               end
            end else if (!popn_ff) begin
               a_ff     <= top_ff;
               popn_ff  <= 1'b1;
               state_ff <= S_POP0;
            end else begin
               b_ff     <= top_ff;
               state_ff <= S_SUMA;
            end
         end
      end
   end

   hcb_walk_stack #(
      .DEPTH   (MAX_SYMBOLS),
      .ENTRY_W (ENTRY_W)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .ctl       (stk_ctl),
      .push_data (stk_push),
      .pop_data  (stk_pop),
      .empty     (stk_empty)
   );

   hcb_wsum_acc #(
      .WT_W (W_W)
   ) u_acc (
      .clock  (clock),
      .reset  (reset),
      .ctl    (acc_ctl),
      .weight (wgt_rd_ff),
      .depth  (dep_ff),
      .wsum   (wsum)
   );

   `HCB_NEVER(a_rsp_busy, clock, reset, rsp_tvalid && req_tready)
   `HCB_ASSERT(a_loaded_max, clock, reset, loaded_ff <= CNT_W'(MAX_SYMBOLS))
   `HCB_ASSERT(a_heap_max, clock, reset, cnt_ff <= CNT_W'(MAX_SYMBOLS))
   `HCB_ASSERT(a_last_done, clock, reset, (rsp_acc && rsp_tlast) |=> (state_ff == S_LOAD))
endmodule
`default_nettype wire
